// ----- hw/rtl/tgps_pkg.sv -----
// Shared types and fixed-point constants for the two-grain pitch shifter.
package tgps_pkg;

  // Field widths of the stream items.
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned RATIO_W  = 16;

  // Fractional bits of phases and read positions.
  localparam int unsigned FRAC_W = 16;

  // Hann weight, unsigned Q1.15 (largest value is exactly 1.0).
  localparam int unsigned WIN_W = 16;

  // Phase step is (RATIO_ONE - ratio) * 4 in samples with FRAC_W fractional bits.
  localparam int unsigned RATIO_ONE  = 16384;
  localparam int unsigned STEP_SHIFT = 2;
  localparam int unsigned STEP_W     = 19;

  // Each grain reads two samples further back than its phase.
  localparam int unsigned READ_LAG = 131072;

  // Shared multiplier: signed operand A times signed operand B.
  localparam int unsigned OPA_W  = SAMPLE_W + 1;
  localparam int unsigned OPB_W  = FRAC_W + 1;
  localparam int unsigned PROD_W = OPA_W + OPB_W;

  // Interpolated grain value and its split for the weighting multiply.
  localparam int unsigned V_W  = 40;
  localparam int unsigned VL_W = 20;
  localparam int unsigned VH_W = V_W - VL_W;

  // Accumulator and final rounding.
  localparam int unsigned ACC_W       = 58;
  localparam int unsigned ROUND_SHIFT = 31;
  localparam int unsigned T_W         = ACC_W - ROUND_SHIFT;

  // Constants for building the window table at elaboration.
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam int unsigned     SIN_TERMS = 12;
  localparam longint unsigned SIN_DIV [SIN_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A0,
    ST_RD_A1,
    ST_RD_B0,
    ST_RD_B1,
    ST_RD_END,
    ST_MAC_V,
    ST_MAC_LO,
    ST_MAC_HI,
    ST_DONE
  } tgps_state_e;

  typedef enum logic [2:0] {
    MAC_IDLE,
    MAC_CLEAR,
    MAC_VSUM,
    MAC_LO,
    MAC_HI
  } mac_op_e;

endpackage

// ----- hw/rtl/tgps_mac.sv -----
// Shared multiply-accumulate unit: interpolation, window weighting, rounding and saturation.
module tgps_mac (
  input  logic                               clk_i,
  input  tgps_pkg::mac_op_e                  op_i,
  input  logic signed [tgps_pkg::SAMPLE_W-1:0] s0_i,
  input  logic signed [tgps_pkg::SAMPLE_W:0]   diff_i,
  input  logic        [tgps_pkg::FRAC_W-1:0]   frac_i,
  input  logic        [tgps_pkg::WIN_W-1:0]    weight_i,
  output logic signed [tgps_pkg::SAMPLE_W-1:0] sample_o
);
  import tgps_pkg::*;

  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] v_sum;
  logic signed [V_W-1:0]    v_d, v_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [T_W-1:0]    t;
  logic                     ovf;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (op_i)
      MAC_VSUM: begin
        opa = diff_i;
        opb = $signed({1'b0, frac_i});
      end
      MAC_LO: begin
        opa = $signed({{(OPA_W - VL_W){1'b0}}, v_q[VL_W-1:0]});
        opb = $signed({1'b0, weight_i});
      end
      MAC_HI: begin
        opa = $signed({{(OPA_W - VH_W){v_q[V_W-1]}}, v_q[V_W-1:VL_W]});
        opb = $signed({1'b0, weight_i});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = opa * opb;

  // v = s0 * 2^16 + (s1 - s0) * f, the same as s0 * (1 - f) + s1 * f scaled by 2^16.
  assign v_sum = (PROD_W'(s0_i) <<< FRAC_W) + prod;

  always_comb begin
    v_d   = v_q;
    acc_d = acc_q;
    unique case (op_i)
      MAC_CLEAR: acc_d = '0;
      MAC_VSUM:  v_d   = v_sum[V_W-1:0];
      MAC_LO:    acc_d = acc_q + ACC_W'(prod);
      MAC_HI:    acc_d = acc_q + (ACC_W'(prod) <<< VL_W);
      default: begin
        v_d   = v_q;
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    acc_q <= acc_d;
  end

  // Round half up, then clip to the sample range.
  assign acc_rnd = acc_q + (ACC_W'(1) <<< (ROUND_SHIFT - 1));
  assign t       = acc_rnd[ACC_W-1:ROUND_SHIFT];
  assign ovf     = t[T_W-1:SAMPLE_W-1] != {(T_W - SAMPLE_W + 1){t[T_W-1]}};

  always_comb begin
    if (ovf) begin
      sample_o = t[T_W-1] ? {1'b1, {(SAMPLE_W - 1){1'b0}}} : {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end else begin
      sample_o = t[SAMPLE_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/two_grain_delay_pitch_shifter.sv -----
// Top level of the two-grain delay-line pitch shifter with Hann windowed grains.
//
// Each input item carries one Q1.23 sample and a Q2.14 pitch ratio; each one gives exactly one
// Q1.23 output item, saturated. The sample goes into a circular delay line of DELAY_DEPTH
// entries, and two grains, half a grain apart, read it back with linear interpolation at a
// delay that sweeps by (1 - ratio) samples per item over GRAIN_LENGTH samples. An item is
// worked on from acceptance until the block takes the next one: five accesses on the
// single-port delay memory (one write, four interpolation taps), six steps on the shared
// multiplier (interpolation and two halves of the window weighting per grain) and a last step
// to round and hand the result to the output register. The result waits in that register
// while the next item is already being worked on. All three parameters must be powers of two.
// Entries of the delay line that have not been written since reset read as zero, so the line
// needs no clearing pass and the block is ready right after reset.
module two_grain_delay_pitch_shifter #(
  parameter int unsigned DELAY_DEPTH       = 4096,
  parameter int unsigned GRAIN_LENGTH      = 1024,
  parameter int unsigned WINDOW_TABLE_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [23:0] sample_in, [39:24] shift_ratio
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [23:0] sample_out
);
  import tgps_pkg::*;

  localparam int unsigned AW     = $clog2(DELAY_DEPTH);
  localparam int unsigned PH_W   = $clog2(GRAIN_LENGTH) + FRAC_W;
  localparam int unsigned WT_AW  = $clog2(WINDOW_TABLE_SIZE);
  localparam int unsigned LINE_W = AW + FRAC_W;
  localparam int unsigned DW     = ((PH_W > LINE_W) ? PH_W : LINE_W) + 1;

  // Hann weight round(2^15 * sin^2(pi * k / WINDOW_TABLE_SIZE)), sine by a Taylor series in Q30.
  function automatic logic [WIN_W-1:0] hann_weight(input int unsigned k);
    longint unsigned m, theta, x2, term, s, s2;
    longint          sum;
    int unsigned     n;
    m = (2 * k <= WINDOW_TABLE_SIZE) ? 64'(k) : 64'(WINDOW_TABLE_SIZE - k);
    theta = (PI_Q30 * m) / WINDOW_TABLE_SIZE;
    x2 = (theta * theta) >> 30;
    term = theta;
    sum = longint'(theta);
    for (n = 0; n < SIN_TERMS; n++) begin
      term = ((term * x2) >> 30) / SIN_DIV[n];
      if (n[0] == 1'b0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    s = $unsigned(sum);
    s2 = (s * s) >> 30;
    return WIN_W'((s2 + (64'd1 << 14)) >> 15);
  endfunction

  logic [WIN_W-1:0] win_rom [WINDOW_TABLE_SIZE];

  for (genvar g = 0; g < WINDOW_TABLE_SIZE; g++) begin : g_win
    assign win_rom[g] = hann_weight(g);
  end

  tgps_state_e state_d, state_q;

  logic [AW-1:0]   wi_q;
  logic            full_q;
  logic [PH_W-1:0] phase_a_q, phase_b_q;
  logic            grain_q;
  logic            out_valid_q;
  logic [SAMPLE_W-1:0] out_data_q;

  logic [SAMPLE_W-1:0] delay_mem [DELAY_DEPTH];
  logic [SAMPLE_W-1:0] mem_rdata_q;
  logic                rd_ok_q;
  logic [AW-1:0]       rd_idx_q;

  logic signed [SAMPLE_W-1:0] s0_q   [2];
  logic signed [SAMPLE_W:0]   diff_q [2];
  logic        [FRAC_W-1:0]   frac_q [2];
  logic        [WIN_W-1:0]    win_q  [2];

  logic                in_ready;
  logic                in_accept;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  mac_op_e             mac_op;
  logic [PH_W-1:0]     rd_phase;
  logic [DW-1:0]       delay_sum;
  logic [LINE_W-1:0]   rp;
  logic [AW-1:0]       rp_idx;
  logic [FRAC_W-1:0]   rp_frac;
  logic [WT_AW-1:0]    win_idx;
  logic signed [SAMPLE_W-1:0] rd_sample;
  logic signed [STEP_W-1:0]   step;
  logic                out_load;
  logic signed [SAMPLE_W-1:0] mac_sample;

  assign in_accept = s_axis_tvalid_i && in_ready;

  // Phase step in samples with 16 fractional bits; the wrap modulo a grain is the natural
  // overflow of the phase register because the grain length is a power of two.
  assign step = ($signed(STEP_W'(RATIO_ONE))
                 - $signed({{(STEP_W - RATIO_W){1'b0}}, s_axis_tdata_i[39:24]})) <<< STEP_SHIFT;

  // Read position behind the write head, modulo the line length.
  assign delay_sum = DW'(rd_phase) + DW'(READ_LAG);
  assign rp        = {wi_q, {FRAC_W{1'b0}}} - delay_sum[LINE_W-1:0];
  assign rp_idx    = rp[LINE_W-1:FRAC_W];
  assign rp_frac   = rp[FRAC_W-1:0];
  assign win_idx   = rd_phase[PH_W-1 -: WT_AW];

  assign rd_sample = rd_ok_q ? $signed(mem_rdata_q) : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid_i) state_d = ST_RD_A0;
      ST_RD_A0:  state_d = ST_RD_A1;
      ST_RD_A1:  state_d = ST_RD_B0;
      ST_RD_B0:  state_d = ST_RD_B1;
      ST_RD_B1:  state_d = ST_RD_END;
      ST_RD_END: state_d = ST_MAC_V;
      ST_MAC_V:  state_d = ST_MAC_LO;
      ST_MAC_LO: state_d = ST_MAC_HI;
      ST_MAC_HI: state_d = grain_q ? ST_DONE : ST_MAC_V;
      ST_DONE:   if (!out_valid_q || m_axis_tready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    mem_addr = rd_idx_q + AW'(1);
    mac_op   = MAC_IDLE;
    rd_phase = phase_a_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_we   = s_axis_tvalid_i;
        mem_addr = wi_q;
        mac_op   = s_axis_tvalid_i ? MAC_CLEAR : MAC_IDLE;
      end
      ST_RD_A0: begin
        mem_addr = rp_idx;
      end
      ST_RD_B0: begin
        rd_phase = phase_b_q;
        mem_addr = rp_idx;
      end
      ST_MAC_V:  mac_op = MAC_VSUM;
      ST_MAC_LO: mac_op = MAC_LO;
      ST_MAC_HI: mac_op = MAC_HI;
      ST_DONE:   out_load = !out_valid_q || m_axis_tready_i;
      default: begin
        mac_op = MAC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wi_q        <= '0;
      full_q      <= 1'b0;
      phase_a_q   <= '0;
      phase_b_q   <= {1'b1, {(PH_W - 1){1'b0}}};
      grain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        wi_q      <= wi_q + AW'(1);
        full_q    <= full_q || (wi_q == {AW{1'b1}});
        phase_a_q <= phase_a_q + PH_W'(step);
        phase_b_q <= phase_b_q + PH_W'(step);
        grain_q   <= 1'b0;
      end else if (state_q == ST_MAC_HI) begin
        grain_q <= ~grain_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Delay memory: one port, read data registered. Entries not yet written since reset are
  // masked to zero by the fill tracking (write head plus a wrapped flag).
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      delay_mem[mem_addr] <= s_axis_tdata_i[SAMPLE_W-1:0];
    end
    mem_rdata_q <= delay_mem[mem_addr];
    rd_ok_q     <= full_q || (mem_addr < wi_q);
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_RD_A0: begin
        rd_idx_q  <= rp_idx;
        frac_q[0] <= rp_frac;
        win_q[0]  <= win_rom[win_idx];
      end
      ST_RD_A1: s0_q[0] <= rd_sample;
      ST_RD_B0: begin
        diff_q[0] <= $signed({rd_sample[SAMPLE_W-1], rd_sample})
                     - $signed({s0_q[0][SAMPLE_W-1], s0_q[0]});
        rd_idx_q  <= rp_idx;
        frac_q[1] <= rp_frac;
        win_q[1]  <= win_rom[win_idx];
      end
      ST_RD_B1: s0_q[1] <= rd_sample;
      ST_RD_END: begin
        diff_q[1] <= $signed({rd_sample[SAMPLE_W-1], rd_sample})
                     - $signed({s0_q[1][SAMPLE_W-1], s0_q[1]});
      end
      ST_DONE: begin
        if (out_load) begin
          out_data_q <= mac_sample;
        end
      end
      default: begin
        rd_idx_q <= rd_idx_q;
      end
    endcase
  end

  tgps_mac u_mac (
    .clk_i    (clk_i),
    .op_i     (mac_op),
    .s0_i     (s0_q[grain_q]),
    .diff_i   (diff_q[grain_q]),
    .frac_i   (frac_q[grain_q]),
    .weight_i (win_q[grain_q]),
    .sample_o (mac_sample)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ----- test/two_grain_delay_pitch_shifter_test.sv -----
// Self-checking stream testbench for the two-grain delay-line pitch shifter.
module two_grain_delay_pitch_shifter_test;
  import tgps_pkg::*;

  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned GRAIN     = 1024;
  localparam int unsigned WIN_SIZE  = 256;
  localparam longint PHASE_SPAN     = longint'(GRAIN) * 65536;
  localparam longint LINE_SPAN      = longint'(DEPTH) * 65536;
  localparam int unsigned NUM_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

  // Keeps a shadow copy of the delay line and both grain phases and queues
  // the output sample that each accepted item should produce.
  class pitch_shift_board;
    logic signed [23:0] line_mem [DEPTH];
    int unsigned        head;
    longint             phase_a;
    longint             phase_b;
    longint             hann_tab [WIN_SIZE];
    logic [23:0]        pending_out [$];
    int unsigned        n_taken;
    int unsigned        n_errors;

    function new();
      longint unsigned m, theta, s, s2;
      foreach (line_mem[i]) line_mem[i] = '0;
      head     = 0;
      phase_a  = 0;
      phase_b  = PHASE_SPAN / 2;
      n_taken  = 0;
      n_errors = 0;
      // Hann weights in Q1.15, built from a fixed-point Taylor sine.
      for (int k = 0; k < WIN_SIZE; k++) begin
        m     = (2 * k <= WIN_SIZE) ? longint'(k) : longint'(WIN_SIZE - k);
        theta = (PI_Q30 * m) / WIN_SIZE;
        s     = sine_q30(theta);
        s2    = (s * s) >> 30;
        hann_tab[k] = longint'((s2 + 16384) >> 15);
      end
    endfunction

    function automatic longint unsigned sine_q30(longint unsigned x);
      longint unsigned x2, term;
      longint          acc;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      return longint'(acc);
    endfunction

    function automatic longint wrap_phase(longint p);
      if (p < 0) return p + PHASE_SPAN;
      if (p >= PHASE_SPAN) return p - PHASE_SPAN;
      return p;
    endfunction

    function automatic longint weight_of(longint p);
      longint k;
      k = (p * WIN_SIZE) / PHASE_SPAN;
      if (k >= WIN_SIZE) k = WIN_SIZE - 1;
      return hann_tab[k];
    endfunction

    // Linear interpolation between two taps, Q1.23 scaled by 2^16.
    function automatic longint tap_blend(longint p);
      longint lag, rpos, i0, i1, frac;
      lag  = (p + longint'(READ_LAG)) % LINE_SPAN;
      rpos = (longint'(head) << 16) + LINE_SPAN - lag;
      if (rpos >= LINE_SPAN) rpos = rpos - LINE_SPAN;
      i0   = rpos >> 16;
      i1   = (i0 + 1) % DEPTH;
      frac = rpos & 64'hFFFF;
      return longint'(line_mem[i0]) * (65536 - frac) + longint'(line_mem[i1]) * frac;
    endfunction

    function automatic logic [23:0] shift_one(logic signed [23:0] smp, logic [15:0] ratio);
      longint step, mix, y;
      step = (longint'(RATIO_ONE) - longint'(ratio)) * 4;
      line_mem[head] = smp;
      head    = (head + 1) % DEPTH;
      phase_a = wrap_phase(phase_a + step);
      phase_b = wrap_phase(phase_b + step);
      mix = tap_blend(phase_a) * weight_of(phase_a) + tap_blend(phase_b) * weight_of(phase_b);
      y = (mix + (longint'(1) <<< 30)) >>> 31;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      return y[23:0];
    endfunction

    function void take_sample(logic signed [23:0] smp, logic [15:0] ratio);
      pending_out.push_back(shift_one(smp, ratio));
      n_taken++;
    endfunction

    function void check_output(logic [23:0] got);
      logic [23:0] want;
      if (pending_out.size() == 0) begin
        $error("sample_out: no item expected, actual %0d", $signed(got));
        n_errors++;
      end else begin
        want = pending_out.pop_front();
        if (want !== got) begin
          $error("sample_out mismatch: expected %0d, actual %0d", $signed(want), $signed(got));
          n_errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;  // [23:0] sample_in, [39:24] shift_ratio
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;       // [23:0] sample_out

  pitch_shift_board board = new();

  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  two_grain_delay_pitch_shifter #(
    .DELAY_DEPTH      (DEPTH),
    .GRAIN_LENGTH     (GRAIN),
    .WINDOW_TABLE_SIZE(WIN_SIZE)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Output side: switches between stall patterns, and once holds off for a
  // long stretch so that the block backs up into its input.
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) board.check_output(m_axis_tdata_o);
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(50, 400);
    end else begin
      rx_mode_left--;
    end
    if (!hold_done && board.n_taken >= 400) begin
      hold_done = 1'b1;
      hold_left = 800;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= $urandom_range(0, 1);
        2: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready_i <= (cycle_count % 5 < 3);
      endcase
    end
  end

  task automatic send_item(logic signed [23:0] smp, logic [15:0] ratio);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ratio, smp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.take_sample(smp, ratio);
  endtask

  // Input side: bursts of random length, then a random gap; a zero gap keeps
  // valid high straight into the next burst.
  task automatic send_paced(logic signed [23:0] smp, logic [15:0] ratio);
    int unsigned gap;
    send_item(smp, ratio);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int unsigned        kind, len;
    logic [15:0]        ratio;
    logic signed [23:0] smp;
    logic signed [23:0] ramp;
    logic signed [23:0] ramp_step;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, unity ratio, both nominal ends and ratios far
    // outside the nominal range; full-scale runs push the grain sum to its limits.
    send_item(SAMPLE_MAX, 16'd16384);
    send_item(SAMPLE_MIN, 16'd16384);
    send_item(24'sd0, 16'd8192);
    send_item(-24'sd1, 16'd32768);
    send_item(24'sd1, 16'd0);
    send_item(SAMPLE_MAX, 16'hFFFF);
    send_item(SAMPLE_MIN, 16'hFFFF);
    send_item(24'sh555555, 16'h5555);
    send_item(24'shAAAAAA, 16'hAAAA);
    repeat (6) send_item(SAMPLE_MAX, 16'd8192);
    repeat (6) send_item(SAMPLE_MIN, 16'd32768);
    send_item(SAMPLE_MAX, 16'd0);
    send_item(SAMPLE_MIN, 16'd65535);
    send_paced(24'sd12345, 16'd20000);

    ramp = '0;
    while (board.n_taken < NUM_ITEMS) begin
      kind = $urandom_range(0, 7);
      len  = $urandom_range(8, 60);
      ratio = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(8192, 32768));
      ramp_step = 24'($urandom_range(1, 400000));
      for (int i = 0; i < len; i++) begin
        case (kind)
          0: smp = 24'($urandom());
          1: smp = SAMPLE_MAX;
          2: smp = SAMPLE_MIN;
          3: smp = (i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
          4: begin
            ramp = ramp + ramp_step;
            smp  = ramp;
          end
          5: smp = 24'($signed($urandom_range(0, 31)) - 16);
          6: smp = ((i / 4) % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
          default: begin
            smp   = 24'($urandom());
            ratio = 16'($urandom());
          end
        endcase
        send_paced(smp, ratio);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    while (board.pending_out.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (board.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/tgps_pkg.sv
hw/rtl/tgps_mac.sv
hw/rtl/two_grain_delay_pitch_shifter.sv
test/two_grain_delay_pitch_shifter_test.sv
